>>> design/pbmhp_pkg.sv
// Shared types, codes and helper functions for the raw PBM header parser.
`default_nettype none

package pbmhp_pkg;

  // Magic bytes 'P' then '4'
  localparam logic [15:0] MAGIC_WORD = 16'h3450;
  localparam logic [7:0]  MAGIC_B0   = MAGIC_WORD[7:0];
  localparam logic [7:0]  MAGIC_B1   = MAGIC_WORD[15:8];

  localparam logic [7:0]  CHR_HASH   = 8'h23;
  localparam logic [7:0]  CHR_LF     = 8'h0A;
  localparam logic [7:0]  CHR_SPACE  = 8'h20;
  localparam logic [7:0]  CHR_TAB    = 8'h09;
  localparam logic [7:0]  CHR_CR     = 8'h0D;
  localparam logic [7:0]  CHR_ZERO   = 8'h30;
  localparam logic [7:0]  CHR_NINE   = 8'h39;

  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  // Parse phases
  localparam logic [2:0] PH_MAGIC0  = 3'd0;
  localparam logic [2:0] PH_MAGIC1  = 3'd1;
  localparam logic [2:0] PH_W_SKIP  = 3'd2;
  localparam logic [2:0] PH_W_TOKEN = 3'd3;
  localparam logic [2:0] PH_H_SKIP  = 3'd4;
  localparam logic [2:0] PH_H_TOKEN = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MAGIC     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] accumulator;
    logic [15:0] width_held;
    logic [15:0] byte_position;
    logic        in_comment;
    logic        after_comment;
  } pbmhp_state_t;

  localparam pbmhp_state_t STATE_RESET = '{
    phase:         PH_MAGIC0,
    accumulator:   16'd0,
    width_held:    16'd0,
    byte_position: 16'd0,
    in_comment:    1'b0,
    after_comment: 1'b0
  };

  // One header result, with its fire flag
  typedef struct packed {
    logic        fire;
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [13:0] row_bytes;
    logic [15:0] pixel_offset;
  } pbmhp_result_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

endpackage

`default_nettype wire

>>> design/pbm_raw_header_parser_unit.sv
// Top level of the raw PBM (P4) header parser: input register, step logic, result register.
//
//   channel  direction  ports                                   handshake
//   in       input      in_data_byte, in_start_of_file          in_valid / in_stall
//   out      output     out_status, out_width, out_height,      out_valid / out_stall
//                       out_row_bytes, out_pixel_offset
//
// One byte per cycle sustained unless in_stall is raised; a byte is taken into the
// input register, then its result into the result register. The per-byte step is
// a phase update plus one multiply by ten done as shift-and-add.
// rst_n (synchronous, active low) clears the input and result valid flags and
// the parse state; the first byte after reset starts a file.
// While out_stall holds a result, bytes that make no result keep flowing; the
// next byte that makes a result waits in the input register and raises in_stall.
`default_nettype none

module pbm_raw_header_parser_unit
  import pbmhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic [13:0] out_row_bytes,
  output logic [15:0] out_pixel_offset
);

  logic          stg_valid_r;
  logic [7:0]    stg_byte_r;
  logic          stg_sof_r;
  pbmhp_state_t  st_r;
  pbmhp_state_t  st_nxt;
  pbmhp_result_t res;
  logic          advance;
  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [15:0]   width_r;
  logic [15:0]   height_r;
  logic [13:0]   row_bytes_r;
  logic [15:0]   pixel_offset_r;

  pbmhp_step u_step (
    .st            (st_r),
    .data_byte     (stg_byte_r),
    .start_of_file (stg_sof_r),
    .st_nxt        (st_nxt),
    .res           (res)
  );

  // Staged word moves on unless it has a result and the output holds a stalled result
  assign advance  = stg_valid_r && (!res.fire || !out_valid_r || !out_stall);
  assign in_stall = stg_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stg_byte_r <= in_data_byte;
      stg_sof_r  <= in_start_of_file;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      status_r       <= res.status;
      width_r        <= res.width;
      height_r       <= res.height;
      row_bytes_r    <= res.row_bytes;
      pixel_offset_r <= res.pixel_offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_width        = width_r;
  assign out_height       = height_r;
  assign out_row_bytes    = row_bytes_r;
  assign out_pixel_offset = pixel_offset_r;

endmodule

`default_nettype wire

>>> design/pbmhp_step.sv
// Per-byte next-state and result logic of the raw PBM header parser.
`default_nettype none

module pbmhp_step
  import pbmhp_pkg::*;
(
  input  pbmhp_state_t  st,
  input  logic [7:0]    data_byte,
  input  logic          start_of_file,
  output pbmhp_state_t  st_nxt,
  output pbmhp_result_t res
);

  always_comb begin
    pbmhp_state_t cur;
    pbmhp_state_t tok;
    logic         height_part;
    logic         skip_part;
    logic         active;
    logic [15:0]  acc_x10;

    // A start mark restarts the parse with this byte
    cur         = start_of_file ? STATE_RESET : st;
    tok         = cur;
    st_nxt      = cur;
    res         = '0;
    active      = 1'b1;
    height_part = (cur.phase == PH_H_SKIP) || (cur.phase == PH_H_TOKEN);
    skip_part   = (cur.phase == PH_W_SKIP) || (cur.phase == PH_H_SKIP);

    // First non-blank byte of a token opens it fresh
    if (skip_part) begin
      tok.phase         = height_part ? PH_H_TOKEN : PH_W_TOKEN;
      tok.accumulator   = 16'd0;
      tok.in_comment    = 1'b0;
      tok.after_comment = 1'b0;
    end

    // acc * 10 + digit, wrapping at 16 bits
    acc_x10 = {tok.accumulator[12:0], 3'b000} + {tok.accumulator[14:0], 1'b0}
            + {12'd0, data_byte[3:0]};

    case (cur.phase)
      PH_MAGIC0: begin
        if (data_byte == MAGIC_B0) begin
          st_nxt.phase = PH_MAGIC1;
        end else begin
          st_nxt.phase = PH_DONE;
          res.fire     = 1'b1;
          res.status   = ST_MAGIC;
        end
      end
      PH_MAGIC1: begin
        if (data_byte == MAGIC_B1) begin
          st_nxt.phase = PH_W_SKIP;
        end else begin
          st_nxt.phase = PH_DONE;
          res.fire     = 1'b1;
          res.status   = ST_MAGIC;
        end
      end
      PH_W_SKIP, PH_W_TOKEN, PH_H_SKIP, PH_H_TOKEN: begin
        if (!(skip_part && is_ws(data_byte))) begin
          st_nxt = tok;
          if (tok.in_comment) begin
            // Comment runs to LF; a digit must follow
            if (data_byte == CHR_LF) begin
              st_nxt.in_comment    = 1'b0;
              st_nxt.after_comment = 1'b1;
            end
          end else if (tok.after_comment) begin
            st_nxt.after_comment = 1'b0;
            if (is_digit(data_byte)) begin
              st_nxt.accumulator = acc_x10;
            end else begin
              st_nxt.phase = PH_DONE;
              res.fire     = 1'b1;
              res.status   = ST_MALFORMED;
            end
          end else if (is_ws(data_byte)) begin
            if (!height_part) begin
              st_nxt.width_held  = tok.accumulator;
              st_nxt.accumulator = 16'd0;
              st_nxt.phase       = PH_H_SKIP;
            end else begin
              st_nxt.phase     = PH_DONE;
              res.fire         = 1'b1;
              res.status       = ST_OK;
              res.width        = tok.width_held;
              res.height       = tok.accumulator;
              res.row_bytes    = {1'b0, tok.width_held[15:3]}
                               + {13'd0, |tok.width_held[2:0]};
              res.pixel_offset = (cur.byte_position == POS_MAX) ? POS_MAX
                               : cur.byte_position + 16'd1;
            end
          end else if (data_byte == CHR_HASH) begin
            st_nxt.in_comment = 1'b1;
          end else if (is_digit(data_byte)) begin
            st_nxt.accumulator = acc_x10;
          end else begin
            st_nxt.phase = PH_DONE;
            res.fire     = 1'b1;
            res.status   = ST_MALFORMED;
          end
        end
      end
      default: begin
        // Header done: ignore bytes until the next file
        active = 1'b0;
      end
    endcase

    // Saturating byte offset
    if (active && (cur.byte_position != POS_MAX)) begin
      st_nxt.byte_position = cur.byte_position + 16'd1;
    end else begin
      st_nxt.byte_position = cur.byte_position;
    end
  end

endmodule

`default_nettype wire
